/* rtl/core/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared types and constants for the heap allocator and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int HEAP_GRANULES_DEFAULT = 128;

   localparam int REQ_SIZE_W = 12;
   localparam int ADDR_W     = 11;
   localparam int STATUS_W   = 2;

   localparam logic [REQ_SIZE_W-1:0] MAX_REQUEST_RESET = 12'd1592;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic                  command;
      logic [REQ_SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0]     free_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   payload_address;
   } rsp_type;

endpackage

/* rtl/core/ffha_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffha_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Implicit free list over a heap of 16-byte granules with first-fit search.
// ----------------------------------------------------------------------------
// A request is a transfer on req_payload, taken at a clock edge where start is
// high and busy is low. An allocate rounds the payload plus an 8-byte header
// up to whole granules, takes the first free block that fits, splits off the
// remainder and returns the payload offset. A free clears the mark of the
// block whose payload offset matches and merges it with free neighbors.
// Each request gives exactly one result transfer: rsp_valid is high for one
// cycle with rsp_payload, and the receiver must take it then.
// Block headers live in a RAM and the walk reads one header per cycle. A
// request rejected up front goes straight to its result; otherwise the
// walk covers at most HEAP_GRANULES blocks, then splits or merges if needed.
// busy stays high from the accepting edge until the result cycle ends.
// After reset the block writes the single free block that spans the heap,
// busy high, then accepts requests. max_request resets to 1592; the user
// must write it via csr_wr_en and csr_wr_data only while idle (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int HEAP_GRANULES = HEAP_GRANULES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [REQ_SIZE_W-1:0] csr_wr_data
);

   localparam int GW     = $clog2(HEAP_GRANULES);
   localparam int SW     = $clog2(HEAP_GRANULES + 1);
   localparam int NEED_W = 9;
   localparam int TGT_W  = ADDR_W - 4;
   localparam int WIDE_W = (SW + 1 > NEED_W) ? SW + 1 : NEED_W;
   localparam int ENT_W  = SW + 1;

   localparam logic [WIDE_W-1:0] HEAP_W = WIDE_W'(HEAP_GRANULES);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_AWALK  = 3'd2;
   localparam logic [2:0] S_ASPLIT = 3'd3;
   localparam logic [2:0] S_FWALK  = 3'd4;
   localparam logic [2:0] S_FMERGE = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [REQ_SIZE_W-1:0] max_req_ff;
   logic [SW-1:0]         pos_ff, pos_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic [TGT_W-1:0]      target_ff, target_in;
   logic [SW-1:0]         prev_pos_ff, prev_pos_in;
   logic [SW-1:0]         prev_size_ff, prev_size_in;
   logic                  prev_free_ff, prev_free_in;
   logic [SW-1:0]         cur_size_ff, cur_size_in;
   logic                  next_ok_ff, next_ok_in;
   logic [GW-1:0]         aux_pos_ff, aux_pos_in;
   logic [SW-1:0]         aux_size_ff, aux_size_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ADDR_W-1:0]     paddr_ff, paddr_in;

   logic              wr_en;
   logic [GW-1:0]     wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic [GW-1:0]     rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic              q_used;
   logic [SW-1:0]     q_size;
   logic [WIDE_W-1:0] next_sum;
   logic [WIDE_W-1:0] merge_total;
   logic [SW-1:0]     merge_start;

   ffha_ram #(
      .WIDTH (ENT_W),
      .DEPTH (HEAP_GRANULES)
   ) u_headers (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign q_used   = rd_data[ENT_W-1];
   assign q_size   = rd_data[SW-1:0];
   assign next_sum = WIDE_W'(pos_ff) + WIDE_W'(q_size);

   assign merge_total = (prev_free_ff ? WIDE_W'(prev_size_ff) : '0) + WIDE_W'(cur_size_ff)
                      + ((next_ok_ff && !q_used) ? WIDE_W'(q_size) : '0);
   assign merge_start = prev_free_ff ? prev_pos_ff : pos_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      need_in      = need_ff;
      target_in    = target_ff;
      prev_pos_in  = prev_pos_ff;
      prev_size_in = prev_size_ff;
      prev_free_in = prev_free_ff;
      cur_size_in  = cur_size_ff;
      next_ok_in   = next_ok_ff;
      aux_pos_in   = aux_pos_ff;
      aux_size_in  = aux_size_ff;
      status_in    = status_ff;
      paddr_in     = paddr_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      unique case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_data  = {1'b0, SW'(HEAP_GRANULES)};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            pos_in       = '0;
            paddr_in     = '0;
            prev_free_in = 1'b0;
            if (start) begin
               if (req_payload.command == CMD_ALLOC) begin
                  status_in = STATUS_NO_FIT;
                  need_in   = NEED_W'((13'(req_payload.request_size) + 13'd23) >> 4);
                  if (req_payload.request_size > max_req_ff) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_AWALK;
                  end
               end else begin
                  status_in = STATUS_BAD_FREE;
                  target_in = req_payload.free_address[ADDR_W-1:4];
                  if (req_payload.free_address[3:0] != 4'd8) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FWALK;
                  end
               end
            end
         end
         S_AWALK: begin
            rd_addr = next_sum[GW-1:0];
            if (!q_used && WIDE_W'(q_size) >= WIDE_W'(need_ff)) begin
               wr_en       = 1'b1;
               wr_addr     = pos_ff[GW-1:0];
               wr_data     = {1'b1, SW'(need_ff)};
               status_in   = STATUS_OK;
               paddr_in    = ADDR_W'({pos_ff, 4'd8});
               aux_pos_in  = GW'(WIDE_W'(pos_ff) + WIDE_W'(need_ff));
               aux_size_in = SW'(WIDE_W'(q_size) - WIDE_W'(need_ff));
               if (WIDE_W'(q_size) > WIDE_W'(need_ff)) begin
                  state_in = S_ASPLIT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (next_sum >= HEAP_W) begin
               state_in = S_DONE;
            end else begin
               pos_in = SW'(next_sum);
            end
         end
         S_ASPLIT: begin
            wr_en    = 1'b1;
            wr_addr  = aux_pos_ff;
            wr_data  = {1'b0, aux_size_ff};
            state_in = S_DONE;
         end
         S_FWALK: begin
            rd_addr = next_sum[GW-1:0];
            if (WIDE_W'(pos_ff) == WIDE_W'(target_ff)) begin
               cur_size_in = q_size;
               next_ok_in  = next_sum < HEAP_W;
               if (q_used) begin
                  state_in = S_FMERGE;
               end else begin
                  state_in = S_DONE;
               end
            end else if (WIDE_W'(pos_ff) > WIDE_W'(target_ff) || next_sum >= HEAP_W) begin
               state_in = S_DONE;
            end else begin
               prev_pos_in  = pos_ff;
               prev_size_in = q_size;
               prev_free_in = !q_used;
               pos_in       = SW'(next_sum);
            end
         end
         S_FMERGE: begin
            wr_en     = 1'b1;
            wr_addr   = merge_start[GW-1:0];
            wr_data   = {1'b0, SW'(merge_total)};
            status_in = STATUS_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         max_req_ff <= MAX_REQUEST_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            max_req_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      need_ff      <= need_in;
      target_ff    <= target_in;
      prev_pos_ff  <= prev_pos_in;
      prev_size_ff <= prev_size_in;
      prev_free_ff <= prev_free_in;
      cur_size_ff  <= cur_size_in;
      next_ok_ff   <= next_ok_in;
      aux_pos_ff   <= aux_pos_in;
      aux_size_ff  <= aux_size_in;
      status_ff    <= status_in;
      paddr_ff     <= paddr_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   assign rsp_payload.status          = status_ff;
   assign rsp_payload.payload_address = paddr_ff;

endmodule

/* rtl/core/ffha_checker.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Port-level assertions on the request and result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffha_assertions
   import ffha_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted request did not raise busy.");

   a_result_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("Result transfer shown while idle.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("Result strobe longer than one cycle or busy after result.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_OK ||
                     rsp_payload.status == STATUS_NO_FIT ||
                     rsp_payload.status == STATUS_BAD_FREE))
      else $error("Undefined status code.");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.payload_address == '0)
      else $error("Nonzero address on a failed request.");

endmodule

bind first_fit_heap_allocator ffha_assertions u_ffha_assertions (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
